[hw/rtl/sxc_pkg.sv]
// Shared constants for the sliding cross-correlation peak-lag block.
// No dependencies; imported by the top level.
package sxc_pkg;

	// Default number of lags (window length and lag count).
	localparam int LAGS_DEFAULT = 128;

	// Field widths of the stream payloads.
	localparam int SAMPLE_W  = 8;
	localparam int BEST_LAG_W = 7;
	localparam int MAG_W     = 16;
	localparam int SUM_W     = 16;

	// Packed widths on the stream buses, rounded up to whole bytes.
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	// Absolute value of a wrapping 16-bit sum read as two's complement.
	function automatic logic [MAG_W-1:0] sum_magnitude(input logic [SUM_W-1:0] v);
		logic [MAG_W-1:0] r;
		r = v[SUM_W-1] ? MAG_W'(~v + SUM_W'(1)) : MAG_W'(v);
		return r;
	endfunction

endpackage

[hw/rtl/sxc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for rings, window sums and product history.
module sxc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/sliding_xcorr_peak_lag_top.sv]
// Sliding cross-correlation peak-lag estimator, top level.
// Depends on sxc_pkg and sxc_ram.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  [7:0] sample_a, [15:8] sample_b
//  m_axis    out  m_axis_tvalid / m_axis_tready  [6:0] best_lag, [22:7] best_magnitude
//
// A transaction steps through the accept cycle, a load state to fetch the centre sample,
// one issue per lag of the shared multiply and read-modify-write unit (one lag per
// cycle through the sum and history RAM ports), a drain of stages s1 and s2 and the
// load of the result register.
// After reset a clearing pass over every history address zeroes all memories;
// s_axis_tready stays low meanwhile.
// A result waiting on m_axis does not block the next input; the block stalls only
// at the end of an item while the previous result has not been taken.
module sliding_xcorr_peak_lag_top
	import sxc_pkg::*;
#(
	parameter int LAGS = LAGS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] sample_a, [15:8] sample_b
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // [6:0] best_lag, [22:7] best_magnitude, [23] zero
);

	localparam int RING_LEN  = 2 * LAGS;
	localparam int HALF_LAGS = LAGS / 2;
	localparam int SPAN      = 2 * HALF_LAGS;
	localparam int HIST_LEN  = LAGS * LAGS;
	localparam int LAG_AW    = $clog2(LAGS);
	localparam int RING_AW   = $clog2(RING_LEN);
	localparam int HIST_AW   = $clog2(HIST_LEN);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	logic [2:0]          state_q;
	logic [HIST_AW-1:0]  clr_q;
	logic [RING_AW-1:0]  wp_q;
	logic [RING_AW-1:0]  bptr_q;
	logic [LAG_AW-1:0]   row_q;
	logic [HIST_AW-1:0]  hist_base_q;
	logic [LAG_AW-1:0]   t_q;

	logic                v_s1_q;
	logic                upd_s1_q;
	logic [LAG_AW-1:0]   t_s1_q;
	logic [HIST_AW-1:0]  haddr_s1_q;
	logic                v_s2_q;
	logic [LAG_AW-1:0]   t_s2_q;
	logic [SUM_W-1:0]    sum_s2_q;

	logic [LAG_AW-1:0]   best_q;
	logic [MAG_W-1:0]    best_mag_q;
	logic [OUT_DATA_W-1:0] out_q;
	logic                out_valid_q;

	logic                accept;
	logic                clearing;
	logic                issue;
	logic                finish;
	logic [RING_AW:0]    centre_w;
	logic [RING_AW:0]    start_w;
	logic [RING_AW:0]    row_w;
	logic [HIST_AW-1:0]  haddr;

	logic                ring_we;
	logic [RING_AW-1:0]  ring_waddr;
	logic [SAMPLE_W-1:0] ra_wdata;
	logic [SAMPLE_W-1:0] rb_wdata;
	logic [SAMPLE_W-1:0] ra_rdata;
	logic [SAMPLE_W-1:0] rb_rdata;
	logic                sum_we;
	logic [LAG_AW-1:0]   sum_waddr;
	logic [SUM_W-1:0]    sum_rdata;
	logic                hist_we;
	logic [HIST_AW-1:0]  hist_waddr;
	logic [SUM_W-1:0]    hist_rdata;
	logic [SUM_W-1:0]    new_sum;
	logic [SUM_W-1:0]    prod;
	logic [MAG_W-1:0]    mag_s2;

	assign clearing      = (state_q == ST_CLEAR);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign issue         = (state_q == ST_RUN);
	assign finish        = (state_q == ST_DRAIN) && !v_s1_q && !v_s2_q &&
	                       (!out_valid_q || m_axis_tready);

	// Ring positions of the centre sample, the window start and the history row
	always_comb begin
		centre_w = ({1'b0, wp_q} >= (RING_AW+1)'(HALF_LAGS)) ?
		           {1'b0, wp_q} - (RING_AW+1)'(HALF_LAGS) :
		           {1'b0, wp_q} + (RING_AW+1)'(RING_LEN - HALF_LAGS);
		start_w  = ({1'b0, wp_q} >= (RING_AW+1)'(SPAN)) ?
		           {1'b0, wp_q} - (RING_AW+1)'(SPAN) :
		           {1'b0, wp_q} + (RING_AW+1)'(RING_LEN - SPAN);
		row_w    = (start_w >= (RING_AW+1)'(LAGS)) ? start_w - (RING_AW+1)'(LAGS) : start_w;
	end

	assign haddr = hist_base_q + HIST_AW'(t_q);

	// Memory write muxes: clearing pass or normal operation
	always_comb begin
		if (clearing) begin
			ring_we    = ({1'b0, clr_q} < (HIST_AW+1)'(RING_LEN));
			ring_waddr = clr_q[RING_AW-1:0];
			ra_wdata   = '0;
			rb_wdata   = '0;
			sum_we     = (clr_q < HIST_AW'(LAGS));
			sum_waddr  = clr_q[LAG_AW-1:0];
			hist_we    = 1'b1;
			hist_waddr = clr_q;
		end else begin
			ring_we    = accept;
			ring_waddr = wp_q;
			ra_wdata   = s_axis_tdata[SAMPLE_W-1:0];
			rb_wdata   = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
			sum_we     = v_s1_q && upd_s1_q;
			sum_waddr  = t_s1_q;
			hist_we    = v_s1_q && upd_s1_q;
			hist_waddr = haddr_s1_q;
		end
	end

	// Shared unit: one product and window-sum update per cycle
	assign prod    = SUM_W'({{SAMPLE_W{ra_rdata[SAMPLE_W-1]}}, ra_rdata} *
	                        {{SAMPLE_W{rb_rdata[SAMPLE_W-1]}}, rb_rdata});
	assign new_sum = upd_s1_q ? (sum_rdata - hist_rdata + prod) : sum_rdata;
	assign mag_s2  = sum_magnitude(sum_s2_q);

	sxc_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_LEN)) u_ring_first (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ra_wdata),
		.re    (accept),
		.raddr (centre_w[RING_AW-1:0]),
		.rdata (ra_rdata)
	);

	sxc_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_LEN)) u_ring_second (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (rb_wdata),
		.re    (issue),
		.raddr (bptr_q),
		.rdata (rb_rdata)
	);

	sxc_ram #(.WIDTH(SUM_W), .DEPTH(LAGS)) u_lag_sums (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (clearing ? '0 : new_sum),
		.re    (issue),
		.raddr (t_q),
		.rdata (sum_rdata)
	);

	sxc_ram #(.WIDTH(SUM_W), .DEPTH(HIST_LEN)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (clearing ? '0 : prod),
		.re    (issue),
		.raddr (haddr),
		.rdata (hist_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			wp_q    <= '0;
			t_q     <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == HIST_AW'(HIST_LEN - 1)) begin
						state_q <= ST_IDLE;
					end
					clr_q <= clr_q + HIST_AW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						wp_q    <= (wp_q == RING_AW'(RING_LEN - 1)) ? '0 : wp_q + RING_AW'(1);
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					t_q     <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					t_q <= t_q + LAG_AW'(1);
					if (t_q == LAG_AW'(LAGS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-item addressing, captured at accept and in the load cycle; the second-ring pointer then advances on each issue
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= row_w[LAG_AW-1:0];
		end
		if (state_q == ST_LOAD) begin
			hist_base_q <= HIST_AW'(row_q) * HIST_AW'(LAGS);
		end
		if (accept) begin
			bptr_q <= start_w[RING_AW-1:0];
		end else if (issue) begin
			bptr_q <= (bptr_q == RING_AW'(RING_LEN - 1)) ? '0 : bptr_q + RING_AW'(1);
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			v_s1_q <= issue;
			v_s2_q <= v_s1_q;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		t_s1_q     <= t_q;
		upd_s1_q   <= (32'(t_q) < SPAN);
		haddr_s1_q <= haddr;
		t_s2_q     <= t_s1_q;
		sum_s2_q   <= new_sum;
	end

	// Track the first lag with the largest magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			best_mag_q <= '0;
		end else if (accept) begin
			best_q     <= '0;
			best_mag_q <= '0;
		end else if (v_s2_q && (mag_s2 > best_mag_q)) begin
			best_q     <= t_s2_q;
			best_mag_q <= mag_s2;
		end
	end

	// Result register: load at item end, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q <= {1'b0, best_mag_q, BEST_LAG_W'(best_q)};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// No lag work in flight while the block takes input
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!v_s1_q && !v_s2_q))
		else $error("pipeline busy while ready");

	// Peak search restarts on each item
	a_best_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (best_mag_q == '0 && best_q == '0))
		else $error("peak not cleared at accept");

	// No result during the clearing pass
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!m_axis_tvalid && !s_axis_tready))
		else $error("activity during clearing pass");

	// A new result comes only from the end of an item's drain
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DRAIN))
		else $error("result raised outside drain");

	// Window-sum updates happen only during lag work or clearing
	a_write_scope: assert property (@(posedge clk) disable iff (!arst_n)
		sum_we |-> (clearing || v_s1_q))
		else $error("window sum written out of sequence");

endmodule

[verif/sliding_xcorr_peak_lag_top_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sliding_xcorr_peak_lag_top: streams sample pairs in,
// predicts each peak lag and magnitude in-house and compares every result transaction.
// Depends on sxc_pkg and the RTL of the block; needs no files or arguments.
module sliding_xcorr_peak_lag_top_test;
	import sxc_pkg::*;

	localparam int LAGS = LAGS_DEFAULT;
	localparam int HALF = LAGS / 2;
	localparam int RING = 2 * LAGS;
	localparam int QUIET_LIMIT = 80000;   // clearing pass plus long stalls, several times over
	localparam int PHASE_PAIRS = 425;

	typedef struct packed {
		logic [BEST_LAG_W-1:0] lag;
		logic [MAG_W-1:0]      mag;
	} peak_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] a;
		logic signed [SAMPLE_W-1:0] b;
		logic [BEST_LAG_W-1:0]      lag;
		logic [MAG_W-1:0]           mag;
	} pair_row_t;

	typedef enum int {RUN_NOISE, RUN_ECHO, RUN_RAIL, RUN_QUIET, RUN_SPARSE} run_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_valid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_data = '0;
	logic                  m_axis_tvalid;
	logic                  m_ready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// side info that travels with the transaction on the input bus
	logic                  row_typed = 1'b0;
	peak_t                 row_peak = '0;

	// predictor state
	logic signed [SAMPLE_W-1:0] ring_a [RING] = '{default: '0};
	logic signed [SAMPLE_W-1:0] ring_b [RING] = '{default: '0};
	logic [SUM_W-1:0]           prod_hist [LAGS][LAGS] = '{default: '{default: '0}};
	logic [SUM_W-1:0]           win_sum [LAGS] = '{default: '0};
	int                         wr_pos = 0;

	peak_t peak_expect[$];
	int    idle_pct = 0;
	int    hold_pct = 0;
	int    pairs_sent = 0;
	int    peaks_checked = 0;
	int    mismatch_cnt = 0;
	int    quiet_cycles = 0;
	int    peak_top = 0;

	// All rows fall before the centre sample is ever written, so every window sum
	// is still zero: lag 0, magnitude 0.
	pair_row_t pair_rows [16] = '{
		'{8'sd127, 8'sd127, 7'd0, 16'd0},
		'{-8'sd128, -8'sd128, 7'd0, 16'd0},
		'{8'sd127, -8'sd128, 7'd0, 16'd0},
		'{-8'sd128, 8'sd127, 7'd0, 16'd0},
		'{8'sd0, 8'sd0, 7'd0, 16'd0},
		'{8'sd1, -8'sd1, 7'd0, 16'd0},
		'{-8'sd1, 8'sd1, 7'd0, 16'd0},
		'{8'sd85, -8'sd86, 7'd0, 16'd0},
		'{-8'sd86, 8'sd85, 7'd0, 16'd0},
		'{8'sd15, -8'sd16, 7'd0, 16'd0},
		'{-8'sd16, 8'sd15, 7'd0, 16'd0},
		'{8'sd64, -8'sd64, 7'd0, 16'd0},
		'{-8'sd2, 8'sd2, 7'd0, 16'd0},
		'{8'sd100, -8'sd100, 7'd0, 16'd0},
		'{8'sd0, -8'sd128, 7'd0, 16'd0},
		'{-8'sd128, 8'sd0, 7'd0, 16'd0}
	};

	sliding_xcorr_peak_lag_top #(.LAGS(LAGS)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #6 clk = ~clk;

	// Write one pair into the rings, update every lag window and pick the peak.
	function automatic void xcorr_predict(input logic signed [SAMPLE_W-1:0] a,
			input logic signed [SAMPLE_W-1:0] b, output peak_t res);
		int pos, centre, row, bidx, t;
		logic signed [SAMPLE_W-1:0] av;
		logic signed [SUM_W-1:0] prod;
		logic [SUM_W:0] mag, best;
		pos = wr_pos;
		ring_a[pos] = a;
		ring_b[pos] = b;
		centre = (pos + RING - HALF) % RING;
		av = ring_a[centre];
		row = (pos + RING - 2 * HALF) % LAGS;
		for (t = 0; t < 2 * HALF; t++) begin
			bidx = (centre + RING - HALF + t) % RING;
			prod = av * ring_b[bidx];
			win_sum[t] = win_sum[t] - prod_hist[row][t] + prod;
			prod_hist[row][t] = prod;
		end
		best = '0;
		res = '0;
		for (t = 0; t < LAGS; t++) begin
			mag = win_sum[t][SUM_W-1] ? 17'h10000 - win_sum[t] : {1'b0, win_sum[t]};
			if (mag > best) begin
				best = mag;
				res.lag = BEST_LAG_W'(t);
			end
		end
		res.mag = best[MAG_W-1:0];
		wr_pos = (pos + 1) % RING;
	endfunction

	function automatic void report(input string what, input int unsigned want,
			input int unsigned got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
	endfunction

	// Present one pair after an optional idle gap and hold it until accepted.
	task automatic send_pair(input logic signed [SAMPLE_W-1:0] a,
			input logic signed [SAMPLE_W-1:0] b, input logic typed, input peak_t known);
		int gap;
		@(negedge clk);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 160);
			s_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_valid <= 1'b1;
		s_data <= {b, a};
		row_typed <= typed;
		row_peak <= known;
		do @(posedge clk); while (!(s_valid && s_axis_tready));
		pairs_sent++;
	endtask

	task automatic wait_drained();
		while (peak_expect.size() != 0) @(posedge clk);
	endtask

	// Check results, then queue the expectation for each accepted pair.
	always @(posedge clk) begin
		peak_t got, want;
		if (m_axis_tvalid && m_ready) begin
			got.lag = m_axis_tdata[BEST_LAG_W-1:0];
			got.mag = m_axis_tdata[BEST_LAG_W +: MAG_W];
			if (peak_expect.size() == 0) begin
				report("unexpected result, tdata", 0, m_axis_tdata);
			end else begin
				want = peak_expect.pop_front();
				peaks_checked++;
				if (got.mag > peak_top)
					peak_top = got.mag;
				if (got.lag !== want.lag)
					report("best_lag", want.lag, got.lag);
				if (got.mag !== want.mag)
					report("best_magnitude", want.mag, got.mag);
				if (m_axis_tdata[OUT_DATA_W-1] !== 1'b0)
					report("pad bit", 0, m_axis_tdata[OUT_DATA_W-1]);
			end
		end
		if (s_valid && s_axis_tready) begin
			xcorr_predict(s_data[SAMPLE_W-1:0], s_data[2*SAMPLE_W-1:SAMPLE_W], want);
			peak_expect.push_back(row_typed ? row_peak : want);
		end
	end

	// Watchdog: end the run when no transaction moves for too long.
	always @(posedge clk) begin
		if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Receiver: random stalls, with an occasional long hold that backs up the block.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_pct != 0 && $urandom_range(999) == 0) begin
				m_ready <= 1'b0;
				repeat ($urandom_range(100, 400)) @(negedge clk);
			end else begin
				m_ready <= ($urandom_range(99) >= hold_pct);
			end
		end
	end

	initial begin
		logic signed [SAMPLE_W-1:0] trail [256];
		logic signed [SAMPLE_W-1:0] src, a, b, rail_a, rail_b;
		run_kind_t kind;
		int ph, sent, len, dly, n, k;
		bit flip;
		int ph_idle [4];
		int ph_hold [4];

		ph_idle = '{0, 45, 0, 9};
		ph_hold = '{0, 0, 45, 9};
		for (k = 0; k < 256; k++)
			trail[k] = '0;
		n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows with typed expectations
		foreach (pair_rows[i])
			send_pair(pair_rows[i].a, pair_rows[i].b, 1'b1,
				'{pair_rows[i].lag, pair_rows[i].mag});

		// random runs in four handshake phases; drain fully between phases
		for (ph = 0; ph < 4; ph++) begin
			@(negedge clk);
			s_valid <= 1'b0;
			wait_drained();
			idle_pct = ph_idle[ph];
			hold_pct = ph_hold[ph];
			sent = 0;
			while (sent < PHASE_PAIRS) begin
				kind = run_kind_t'($urandom_range(4));
				len = $urandom_range(16, 180);
				dly = $urandom_range(0, HALF - 1);
				flip = $urandom_range(1);
				rail_a = $urandom_range(1) ? -8'sd128 : 8'sd127;
				rail_b = $urandom_range(1) ? -8'sd128 : 8'sd127;
				for (k = 0; k < len && sent < PHASE_PAIRS; k++) begin
					src = $urandom_range(255);
					trail[n % 256] = src;
					case (kind)
						RUN_NOISE: begin
							a = src;
							b = $urandom_range(255);
						end
						// one channel is a delayed copy of the other: a true peak
						RUN_ECHO: begin
							if (flip) begin
								a = trail[(n + 256 - dly) % 256];
								b = src;
							end else begin
								a = src;
								b = trail[(n + 256 - dly) % 256];
							end
						end
						// full-scale constants drive sums through wrap and -32768
						RUN_RAIL: begin
							a = rail_a;
							b = rail_b;
						end
						RUN_QUIET: begin
							a = '0;
							b = '0;
						end
						default: begin
							a = ($urandom_range(7) == 0) ? rail_a : 8'sd0;
							b = ($urandom_range(7) == 0) ? rail_b : 8'sd0;
						end
					endcase
					send_pair(a, b, 1'b0, '0);
					n++;
					sent++;
				end
			end
		end

		@(negedge clk);
		s_valid <= 1'b0;
		wait_drained();
		repeat (3 * LAGS) @(posedge clk);

		$display("Covered %0d sample pairs (%0d directed) across four idle/stall phases,",
			pairs_sent, $size(pair_rows));
		$display("compared %0d peaks, largest magnitude seen %0d, %0d mismatches.",
			peaks_checked, peak_top, mismatch_cnt);
		if (mismatch_cnt == 0 && peak_expect.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
